FILE: sv/roberts_cross_edge_detector_defines.svh
// Assertion helpers for the Roberts cross edge detector
`ifndef ROBERTS_CROSS_EDGE_DETECTOR_DEFINES_SVH
`define ROBERTS_CROSS_EDGE_DETECTOR_DEFINES_SVH

// same-cycle implication
`define RCED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define RCED_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: sv/rced_pkg.sv
package rced_pkg;

    localparam int PIX_W        = 8;
    localparam int IMG_W_W      = 11;
    localparam int IMG_H_W      = 13;
    localparam int THR_W        = 8;
    localparam int OUT_COL_W    = 10;
    localparam int OUT_ROW_W    = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;

    localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH    = 11'd1024;
    localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT   = 13'd768;
    localparam logic [THR_W-1:0]   RST_EDGE_THRESHOLD = 8'd25;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    localparam int RELIEF_BIAS = 128;
    localparam int BYTE_MAX    = 255;
    localparam int SQRT_STEPS  = 9;

    // square of the gradient pair, rounded root and remainder widths
    localparam int RAD_W  = 18;
    localparam int ROOT_W = 9;
    localparam int REM_W  = 12;

endpackage

FILE: sv/roberts_cross_edge_detector.sv
// Channel  | Strobe / hold            | Payload
// ---------+--------------------------+---------------------------------------------------
// pixel in | i_in_valid / o_in_stall  | i_pixel
// result   | o_out_valid / i_out_stall| o_magnitude o_edge_bit o_relief o_out_col
//          |                          | o_out_row o_last_of_run
// config   | i_cfg_we                 | i_cfg_index i_cfg_data
//
// One pixel at a time: after the line-store read on acceptance, the input stalls through the
// update and, if the pixel has results, the square, 9 root steps and one emit per result.
// The square root is bit-serial; one root serves all results of a pixel.
// Synchronous active-low reset clears control state; the line store is not cleared.
// Output stall holds the result register and the emit state, which also stalls the input.
`include "roberts_cross_edge_detector_defines.svh"

module roberts_cross_edge_detector #(
    parameter int MAX_WIDTH = rced_pkg::DEF_MAX_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [rced_pkg::PIX_W-1:0]       i_pixel,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [rced_pkg::PIX_W-1:0]       o_magnitude,
    output logic                             o_edge_bit,
    output logic [rced_pkg::PIX_W-1:0]       o_relief,
    output logic [rced_pkg::OUT_COL_W-1:0]   o_out_col,
    output logic [rced_pkg::OUT_ROW_W-1:0]   o_out_row,
    output logic                             o_last_of_run,
    input  logic                             i_cfg_we,
    input  logic [rced_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rced_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rced_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WW > IMG_W_W) ? WW : IMG_W_W;
    localparam int RW = OUT_ROW_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;
    localparam logic [1:0] SEL_D = 2'd3;

    logic [IMG_W_W-1:0]     r_image_width;
    logic [IMG_H_W-1:0]     r_image_height;
    logic [THR_W-1:0]       r_edge_threshold;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_col, n_col;
    logic [RW-1:0]          r_row, n_row;
    logic [PIX_W-1:0]       r_left, r_ul;
    logic [PIX_W-1:0]       r_pix, r_rd;
    logic [CW-1:0]          r_c;
    logic [RW-1:0]          r_r;
    logic                   r_lc, r_lr;
    logic signed [8:0]      r_x, r_y;
    logic [RAD_W-1:0]       r_rad;
    logic [ROOT_W-1:0]      r_root;
    logic [REM_W-1:0]       r_rem;
    logic [3:0]             r_step;
    logic [1:0]             r_sel;
    logic                   r_out_valid;
    logic [PIX_W-1:0]       r_mag_o, r_rel_o;
    logic                   r_edge_o, r_last_o;
    logic [OUT_COL_W-1:0]   r_col_o;
    logic [OUT_ROW_W-1:0]   r_row_o;

    logic [PIX_W-1:0]       mem_line [MAX_WIDTH];

    logic [XW-1:0]          w_reg_ext;
    logic [WW-1:0]          eff_w;
    logic [IMG_H_W-1:0]     eff_h;
    logic                   in_xfer, out_free, emit_load;
    logic                   col_wrap;
    logic [IMG_H_W-1:0]     row_pre;
    logic [CW-1:0]          col_start;
    logic [RW-1:0]          row_start;
    logic [WW-1:0]          col_nx;
    logic [IMG_H_W-1:0]     row_nx;
    logic signed [8:0]      x_new, y_new;
    logic signed [17:0]     sq_x, sq_y;
    logic [REM_W-1:0]       rem_sh, trial;
    logic                   round_up;
    logic [ROOT_W:0]        mag_full;
    logic [PIX_W-1:0]       mag;
    logic signed [9:0]      g_sel;
    logic signed [10:0]     rel_sum;
    logic [PIX_W-1:0]       rel;
    logic                   sel_last;
    logic [1:0]             sel_next;
    logic [WW-1:0]          sel_col;
    logic [RW-1:0]          sel_row;

    // effective frame size
    always_comb begin
        w_reg_ext = XW'(r_image_width);
        if (w_reg_ext < XW'(2)) begin
            eff_w = WW'(2);
        end else if (w_reg_ext > XW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(w_reg_ext);
        end
        if (r_image_height < IMG_H_W'(2)) begin
            eff_h = IMG_H_W'(2);
        end else if (r_image_height > IMG_H_W'(MAX_HEIGHT)) begin
            eff_h = IMG_H_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_image_height;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    // position of the incoming pixel, counters wrapped if the size shrank
    always_comb begin
        col_wrap  = (WW'(r_col) >= eff_w);
        row_pre   = col_wrap ? (IMG_H_W'(r_row) + IMG_H_W'(1)) : IMG_H_W'(r_row);
        row_start = (row_pre >= eff_h) ? '0 : RW'(row_pre);
        col_start = col_wrap ? '0 : r_col;
    end

    // counters after this pixel
    always_comb begin
        col_nx = WW'(r_c) + WW'(1);
        row_nx = IMG_H_W'(r_r) + IMG_H_W'(1);
        n_col  = r_col;
        n_row  = r_row;
        if (r_state == S_CALC) begin
            if (col_nx >= eff_w) begin
                n_col = '0;
                n_row = (row_nx >= eff_h) ? '0 : RW'(row_nx);
            end else begin
                n_col = CW'(col_nx);
                n_row = r_r;
            end
        end
    end

    assign x_new = $signed({1'b0, r_pix}) - $signed({1'b0, r_ul});
    assign y_new = $signed({1'b0, r_left}) - $signed({1'b0, r_rd});
    assign sq_x  = r_x * r_x;
    assign sq_y  = r_y * r_y;

    // one root digit per cycle
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = REM_W'({r_root, 2'b01});

    assign round_up = (r_rem > REM_W'(r_root));
    assign mag_full = {1'b0, r_root} + (ROOT_W + 1)'(round_up);
    assign mag      = (mag_full > (ROOT_W + 1)'(BYTE_MAX)) ? PIX_W'(BYTE_MAX)
                                                           : PIX_W'(mag_full);

    always_comb begin
        case (r_sel)
            SEL_A: begin
                g_sel    = 10'(r_x);
                sel_col  = WW'(r_c) - WW'(1);
                sel_row  = r_r - RW'(1);
                sel_last = !r_lc && !r_lr;
                sel_next = r_lc ? SEL_B : SEL_C;
            end
            SEL_B: begin
                g_sel    = 10'(r_y);
                sel_col  = eff_w - WW'(1);
                sel_row  = r_r - RW'(1);
                sel_last = !r_lr;
                sel_next = SEL_C;
            end
            SEL_C: begin
                g_sel    = -10'(r_y);
                sel_col  = WW'(r_c) - WW'(1);
                sel_row  = r_r;
                sel_last = !r_lc;
                sel_next = SEL_D;
            end
            default: begin
                g_sel    = -10'(r_x);
                sel_col  = eff_w - WW'(1);
                sel_row  = r_r;
                sel_last = 1'b1;
                sel_next = SEL_D;
            end
        endcase
        rel_sum = 11'(g_sel) + 11'sd128;
        if (rel_sum < 11'sd0) begin
            rel = '0;
        end else if (rel_sum > 11'(BYTE_MAX)) begin
            rel = PIX_W'(BYTE_MAX);
        end else begin
            rel = PIX_W'(rel_sum);
        end
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_load = (r_state == S_EMIT) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_CALC;
            end
            S_CALC: begin
                n_state = (r_r != '0 && r_c != '0) ? S_SQ : S_IDLE;
            end
            S_SQ: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (r_step == 4'(SQRT_STEPS - 1)) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free && sel_last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_col            <= '0;
            r_row            <= '0;
            r_left           <= '0;
            r_ul             <= '0;
            r_out_valid      <= 1'b0;
            r_image_width    <= RST_IMAGE_WIDTH;
            r_image_height   <= RST_IMAGE_HEIGHT;
            r_edge_threshold <= RST_EDGE_THRESHOLD;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (r_state == S_CALC) begin
                r_left <= r_pix;
                r_ul   <= r_rd;
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data[IMG_W_W-1:0];
                    CFG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_data[IMG_H_W-1:0];
                    CFG_EDGE_THRESHOLD: r_edge_threshold <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (in_xfer) r_rd <= mem_line[col_start];
        if (r_state == S_CALC) mem_line[r_c] <= r_pix;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pix <= i_pixel;
            r_c   <= col_start;
            r_r   <= row_start;
        end
        if (r_state == S_CALC) begin
            r_x  <= x_new;
            r_y  <= y_new;
            r_lc <= (WW'(r_c) == eff_w - WW'(1));
            r_lr <= (IMG_H_W'(r_r) == eff_h - IMG_H_W'(1));
        end
        if (r_state == S_SQ) begin
            r_rad  <= RAD_W'($unsigned(sq_x)) + RAD_W'($unsigned(sq_y));
            r_root <= '0;
            r_rem  <= '0;
            r_step <= '0;
        end
        if (r_state == S_ROOT) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_step <= r_step + 4'd1;
            r_sel  <= SEL_A;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (emit_load) begin
            r_sel    <= sel_next;
            r_mag_o  <= mag;
            r_edge_o <= (mag > r_edge_threshold);
            r_rel_o  <= rel;
            r_col_o  <= OUT_COL_W'(sel_col);
            r_row_o  <= sel_row;
            r_last_o <= sel_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_magnitude   = r_mag_o;
    assign o_edge_bit    = r_edge_o;
    assign o_relief      = r_rel_o;
    assign o_out_col     = r_col_o;
    assign o_out_row     = r_row_o;
    assign o_last_of_run = r_last_o;

    `RCED_ASSERT_IMP(a_edge_matches_mag, r_out_valid, o_edge_bit == (o_magnitude > r_edge_threshold))
    `RCED_ASSERT_NXT(a_accept_to_calc, in_xfer, r_state == S_CALC)
    `RCED_ASSERT_NXT(a_calc_exit, r_state == S_CALC, r_state == S_SQ || r_state == S_IDLE)

endmodule
